FILE: rtl/mgb_pkg.sv
// ----------------------------------------------------------------------------
// Mask gradient package
// Shared types and constants of the mask gradient unit.
// ----------------------------------------------------------------------------
package mgb_pkg;

	localparam int unsigned SAMPLE_BITS = 16;
	localparam int unsigned GRAD_BITS   = 17;
	localparam int unsigned RATIO_BITS  = 16;
	localparam logic [16:0] GRAD_ONE    = 17'h10000;
	localparam logic [16:0] GRAD_ZERO   = 17'h00000;

	// Classification of one item, made by the front end.
	typedef enum logic [2:0] {
		CLS_ONE   = 3'b001,
		CLS_ZERO  = 3'b010,
		CLS_RATIO = 3'b100
	} cls_t;

endpackage

FILE: rtl/mask_gradient_between_boundaries_unit.sv
// ----------------------------------------------------------------------------
// Mask gradient between boundaries
// Per pixel mask value from the distances to the inner and outer boundaries.
// ----------------------------------------------------------------------------
// The unit takes one pixel item in every clock cycle and never raises busy, so
// start may be held high for a whole raster line. Each item yields exactly one
// gradient value, shown for one cycle with done high, after it has passed 3
// register stages for the front end and queue, ROOT_BITS stages for the
// bit-per-stage square roots (21 with default parameters) and 17 stages for
// the bit-per-stage divider, plus the output register. The first front end
// register loads at the accepting edge. Results leave in the order that items
// arrive. The receiver cannot stall the unit and must take every result in the
// cycle it appears.
// ----------------------------------------------------------------------------
module mask_gradient_between_boundaries_unit #(
	parameter int unsigned COORD_BITS     = 12,
	parameter int unsigned DIST_FRAC_BITS = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [COORD_BITS-1:0] pixel_x,
	input  logic [COORD_BITS-1:0] pixel_y,
	input  logic [15:0]           inner_sample,
	input  logic [15:0]           outer_sample,
	input  logic [COORD_BITS-1:0] inner_near_x,
	input  logic [COORD_BITS-1:0] inner_near_y,
	input  logic [COORD_BITS-1:0] outer_near_x,
	input  logic [COORD_BITS-1:0] outer_near_y,
	output logic                  done,
	output logic [16:0]           gradient
);

	localparam int unsigned SQ_BITS = 2 * COORD_BITS + 1;

	logic               f_valid, q_valid;
	mgb_pkg::cls_t      f_cls, q_cls;
	logic [SQ_BITS-1:0] f_sq_in, f_sq_out, q_sq_in, q_sq_out;

	// The pipeline never stalls, so the unit is always ready.
	assign busy = 1'b0;

	mgb_front #(.COORD_BITS(COORD_BITS), .SQ_BITS(SQ_BITS)) u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(start),
		.px(pixel_x), .py(pixel_y), .inner_s(inner_sample), .outer_s(outer_sample),
		.ix(inner_near_x), .iy(inner_near_y), .ox(outer_near_x), .oy(outer_near_y),
		.valid_s2(f_valid), .cls_s2(f_cls), .sq_in_s2(f_sq_in), .sq_out_s2(f_sq_out)
	);

	mgb_queue #(.SQ_BITS(SQ_BITS)) u_queue (
		.clk(clk), .arst_n(arst_n), .valid_i(f_valid), .cls_i(f_cls),
		.sq_in_i(f_sq_in), .sq_out_i(f_sq_out),
		.valid_q(q_valid), .cls_q(q_cls), .sq_in_q(q_sq_in), .sq_out_q(q_sq_out)
	);

	mgb_back #(.SQ_BITS(SQ_BITS), .DIST_FRAC_BITS(DIST_FRAC_BITS)) u_back (
		.clk(clk), .arst_n(arst_n), .valid_i(q_valid), .cls_i(q_cls),
		.sq_in_i(q_sq_in), .sq_out_i(q_sq_out),
		.valid_o(done), .grad_o(gradient)
	);

endmodule

FILE: rtl/mgb_front.sv
// ----------------------------------------------------------------------------
// Mask gradient front end
// Accepts items, classifies them and forms the two squared distances.
// ----------------------------------------------------------------------------
module mgb_front #(
	parameter int unsigned COORD_BITS = 12,
	parameter int unsigned SQ_BITS    = 2 * COORD_BITS + 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic [COORD_BITS-1:0] px,
	input  logic [COORD_BITS-1:0] py,
	input  logic [15:0]           inner_s,
	input  logic [15:0]           outer_s,
	input  logic [COORD_BITS-1:0] ix,
	input  logic [COORD_BITS-1:0] iy,
	input  logic [COORD_BITS-1:0] ox,
	input  logic [COORD_BITS-1:0] oy,
	output logic                  valid_s2,
	output mgb_pkg::cls_t         cls_s2,
	output logic [SQ_BITS-1:0]    sq_in_s2,
	output logic [SQ_BITS-1:0]    sq_out_s2
);

	logic                  valid_s1;
	mgb_pkg::cls_t         cls_s1;
	logic [COORD_BITS-1:0] dix_s1, diy_s1, dox_s1, doy_s1;
	mgb_pkg::cls_t         cls_d;

	function automatic logic [COORD_BITS-1:0] adiff(input logic [COORD_BITS-1:0] a,
		input logic [COORD_BITS-1:0] b);
		return (a > b) ? (a - b) : (b - a);
	endfunction

	always_comb begin
		if (inner_s != '0)
			cls_d = mgb_pkg::CLS_ONE;
		else if (outer_s == '0)
			cls_d = mgb_pkg::CLS_ZERO;
		else
			cls_d = mgb_pkg::CLS_RATIO;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		cls_s1    <= cls_d;
		dix_s1    <= adiff(px, ix);
		diy_s1    <= adiff(py, iy);
		dox_s1    <= adiff(px, ox);
		doy_s1    <= adiff(py, oy);
		cls_s2    <= cls_s1;
		sq_in_s2  <= SQ_BITS'(dix_s1) * SQ_BITS'(dix_s1) + SQ_BITS'(diy_s1) * SQ_BITS'(diy_s1);
		sq_out_s2 <= SQ_BITS'(dox_s1) * SQ_BITS'(dox_s1) + SQ_BITS'(doy_s1) * SQ_BITS'(doy_s1);
	end

endmodule

FILE: rtl/mgb_queue.sv
// ----------------------------------------------------------------------------
// Mask gradient queue
// Short register stage between the front and the back end.
// ----------------------------------------------------------------------------
module mgb_queue #(
	parameter int unsigned SQ_BITS = 25
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               valid_i,
	input  mgb_pkg::cls_t      cls_i,
	input  logic [SQ_BITS-1:0] sq_in_i,
	input  logic [SQ_BITS-1:0] sq_out_i,
	output logic               valid_q,
	output mgb_pkg::cls_t      cls_q,
	output logic [SQ_BITS-1:0] sq_in_q,
	output logic [SQ_BITS-1:0] sq_out_q
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_i;
		end
	end

	// Special cases need no distances; zero them so the root stages idle.
	always_ff @(posedge clk) begin
		cls_q    <= cls_i;
		sq_in_q  <= (cls_i == mgb_pkg::CLS_RATIO) ? sq_in_i : '0;
		sq_out_q <= (cls_i == mgb_pkg::CLS_RATIO) ? sq_out_i : '0;
	end

endmodule

FILE: rtl/mgb_back.sv
// ----------------------------------------------------------------------------
// Mask gradient back end
// Pipelined square roots of both distances and a pipelined restoring divider.
// ----------------------------------------------------------------------------
module mgb_back #(
	parameter int unsigned SQ_BITS        = 25,
	parameter int unsigned DIST_FRAC_BITS = 8,
	parameter int unsigned ROOT_BITS      = (SQ_BITS + 1) / 2 + DIST_FRAC_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               valid_i,
	input  mgb_pkg::cls_t      cls_i,
	input  logic [SQ_BITS-1:0] sq_in_i,
	input  logic [SQ_BITS-1:0] sq_out_i,
	output logic               valid_o,
	output logic [16:0]        grad_o
);

	localparam int unsigned RAD_BITS = 2 * ROOT_BITS;
	localparam int unsigned REM_BITS = ROOT_BITS + 2;
	localparam int unsigned DEN_BITS = ROOT_BITS + 1;
	localparam int unsigned QB       = mgb_pkg::RATIO_BITS + 1;

	// Square root pipeline: one result bit per stage.
	logic [ROOT_BITS:0]               rv;
	mgb_pkg::cls_t                    rc   [ROOT_BITS+1];
	logic [RAD_BITS-1:0]              rad_a [ROOT_BITS+1];
	logic [RAD_BITS-1:0]              rad_b [ROOT_BITS+1];
	logic [REM_BITS-1:0]              rem_a [ROOT_BITS+1];
	logic [REM_BITS-1:0]              rem_b [ROOT_BITS+1];
	logic [ROOT_BITS-1:0]             rt_a  [ROOT_BITS+1];
	logic [ROOT_BITS-1:0]             rt_b  [ROOT_BITS+1];

	assign rv[0]    = valid_i;
	assign rc[0]    = cls_i;
	assign rad_a[0] = RAD_BITS'(sq_in_i) << (2 * DIST_FRAC_BITS);
	assign rad_b[0] = RAD_BITS'(sq_out_i) << (2 * DIST_FRAC_BITS);
	assign rem_a[0] = '0;
	assign rem_b[0] = '0;
	assign rt_a[0]  = '0;
	assign rt_b[0]  = '0;

	function automatic logic [REM_BITS+ROOT_BITS-1:0] rstep(input logic [REM_BITS-1:0] rem,
		input logic [ROOT_BITS-1:0] rt, input logic [1:0] pair);
		logic [REM_BITS-1:0] r;
		logic [REM_BITS-1:0] t;
		r = {rem[REM_BITS-3:0], pair};
		t = {rt[REM_BITS-3:0], 2'b01};
		if (r >= t)
			return {r - t, rt[ROOT_BITS-2:0], 1'b1};
		return {r, rt[ROOT_BITS-2:0], 1'b0};
	endfunction

	for (genvar k = 0; k < ROOT_BITS; k++) begin : g_root
		logic [REM_BITS+ROOT_BITS-1:0] na, nb;
		assign na = rstep(rem_a[k], rt_a[k], rad_a[k][RAD_BITS-1 -: 2]);
		assign nb = rstep(rem_b[k], rt_b[k], rad_b[k][RAD_BITS-1 -: 2]);
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				rv[k+1] <= 1'b0;
			else
				rv[k+1] <= rv[k];
		end
		always_ff @(posedge clk) begin
			rc[k+1]    <= rc[k];
			rad_a[k+1] <= rad_a[k] << 2;
			rad_b[k+1] <= rad_b[k] << 2;
			rem_a[k+1] <= na[REM_BITS+ROOT_BITS-1 -: REM_BITS];
			rem_b[k+1] <= nb[REM_BITS+ROOT_BITS-1 -: REM_BITS];
			rt_a[k+1]  <= na[ROOT_BITS-1:0];
			rt_b[k+1]  <= nb[ROOT_BITS-1:0];
		end
	end

	// Divider: quotient of O * 2^16 / (O + I), one bit per stage.
	logic [QB:0]          dv;
	mgb_pkg::cls_t        dc  [QB+1];
	logic [DEN_BITS-1:0]  den [QB+1];
	logic [DEN_BITS-1:0]  drem[QB+1];
	logic [QB-1:0]        quo [QB+1];
	logic [DEN_BITS-1:0]  o_top;

	assign o_top   = DEN_BITS'(rt_b[ROOT_BITS]);
	assign dv[0]   = rv[ROOT_BITS];
	assign dc[0]   = rc[ROOT_BITS];
	assign den[0]  = DEN_BITS'(rt_a[ROOT_BITS]) + o_top;
	assign drem[0] = '0;
	assign quo[0]  = '0;

	for (genvar k = 0; k < QB; k++) begin : g_div
		logic [DEN_BITS:0] r;
		logic [DEN_BITS:0] rd;
		assign r  = {drem[k], 1'b0};
		assign rd = r - {1'b0, den[k]};
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				dv[k+1] <= 1'b0;
			else
				dv[k+1] <= dv[k];
		end
		always_ff @(posedge clk) begin
			dc[k+1]  <= dc[k];
			den[k+1] <= den[k];
			if (k == 0) begin
				// First stage loads the integer part: quotient bit 16 is O >= den.
				if (o_top >= den[k] && den[k] != '0) begin
					drem[k+1] <= o_top - den[k];
					quo[k+1]  <= QB'(1);
				end else begin
					drem[k+1] <= o_top;
					quo[k+1]  <= '0;
				end
			end else if (!rd[DEN_BITS]) begin
				drem[k+1] <= rd[DEN_BITS-1:0];
				quo[k+1]  <= {quo[k][QB-2:0], 1'b1};
			end else begin
				drem[k+1] <= r[DEN_BITS-1:0];
				quo[k+1]  <= {quo[k][QB-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_o <= 1'b0;
		else
			valid_o <= dv[QB];
	end

	always_ff @(posedge clk) begin
		case (dc[QB])
			mgb_pkg::CLS_ONE:   grad_o <= mgb_pkg::GRAD_ONE;
			mgb_pkg::CLS_ZERO:  grad_o <= mgb_pkg::GRAD_ZERO;
			mgb_pkg::CLS_RATIO: grad_o <= (den[QB] == '0) ? mgb_pkg::GRAD_ZERO : quo[QB];
			default:            grad_o <= mgb_pkg::GRAD_ZERO;
		endcase
	end

endmodule

FILE: dv/mask_gradient_between_boundaries_unit_test.sv
// ----------------------------------------------------------------------------
// Mask gradient unit testbench
// Sends pixel items through the unit under several idling patterns and checks
// every gradient against a predictor that computes the distances and ratio.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mask_gradient_between_boundaries_unit_test;

	localparam int COORD_W = 12;
	localparam int FRAC_W  = 8;
	// Pipeline depth from the unit's description, with margin.
	localparam int PIPE_DEPTH = 50;

	typedef struct packed {
		logic [COORD_W-1:0] px;
		logic [COORD_W-1:0] py;
		logic [15:0]        inner;
		logic [15:0]        outer;
		logic [COORD_W-1:0] ix;
		logic [COORD_W-1:0] iy;
		logic [COORD_W-1:0] ox;
		logic [COORD_W-1:0] oy;
	} pixel_item_t;

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic [COORD_W-1:0]  pixel_x, pixel_y, inner_near_x, inner_near_y;
	logic [COORD_W-1:0]  outer_near_x, outer_near_y;
	logic [15:0]         inner_sample, outer_sample;
	logic                done;
	logic [16:0]         gradient;

	logic [16:0] pending_gradients[$];
	int          mismatch_count;
	int          items_sent;
	int          results_seen;
	int          idle_pct;

	mask_gradient_between_boundaries_unit dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.pixel_x(pixel_x), .pixel_y(pixel_y),
		.inner_sample(inner_sample), .outer_sample(outer_sample),
		.inner_near_x(inner_near_x), .inner_near_y(inner_near_y),
		.outer_near_x(outer_near_x), .outer_near_y(outer_near_y),
		.done(done), .gradient(gradient)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// Square root with FRAC_W fraction bits, truncated, restoring digit by digit.
	function automatic logic [63:0] root_fixed(input logic [63:0] sq);
		logic [63:0] radicand;
		logic [63:0] root;
		logic [63:0] rem;
		logic [63:0] trial;
		radicand = sq << (2 * FRAC_W);
		root = 0;
		rem = 0;
		for (int k = 31; k >= 0; k--) begin
			rem = (rem << 2) | ((radicand >> (2 * k)) & 64'd3);
			trial = (root << 2) | 64'd1;
			if (rem >= trial) begin
				rem = rem - trial;
				root = (root << 1) | 64'd1;
			end else begin
				root = root << 1;
			end
		end
		return root;
	endfunction

	function automatic logic [63:0] boundary_distance(input logic [COORD_W-1:0] ax,
			input logic [COORD_W-1:0] ay, input logic [COORD_W-1:0] bx,
			input logic [COORD_W-1:0] by);
		logic [63:0] dx;
		logic [63:0] dy;
		dx = (ax > bx) ? 64'(ax - bx) : 64'(bx - ax);
		dy = (ay > by) ? 64'(ay - by) : 64'(by - ay);
		return root_fixed(dx * dx + dy * dy);
	endfunction

	// Expected gradient for one pixel item.
	function automatic logic [16:0] predict_gradient(input pixel_item_t it);
		logic [63:0] d_in;
		logic [63:0] d_out;
		logic [63:0] denom;
		if (it.inner != 16'd0)
			return mgb_pkg::GRAD_ONE;
		if (it.outer == 16'd0)
			return mgb_pkg::GRAD_ZERO;
		d_in = boundary_distance(it.px, it.py, it.ix, it.iy);
		d_out = boundary_distance(it.px, it.py, it.ox, it.oy);
		denom = d_in + d_out;
		if (denom == 0)
			return mgb_pkg::GRAD_ZERO;
		return 17'((d_out << 16) / denom);
	endfunction

	// Sends one item, with a random idle gap before it when the phase asks.
	task automatic send_pixel(input pixel_item_t it);
		while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start        <= 1'b1;
		pixel_x      <= it.px;
		pixel_y      <= it.py;
		inner_sample <= it.inner;
		outer_sample <= it.outer;
		inner_near_x <= it.ix;
		inner_near_y <= it.iy;
		outer_near_x <= it.ox;
		outer_near_y <= it.oy;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		pending_gradients.push_back(predict_gradient(it));
		items_sent++;
	endtask

	// Each strobed result is compared with the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && done) begin
			results_seen++;
			if (pending_gradients.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected gradient %0d", gradient);
			end else begin
				logic [16:0] want;
				want = pending_gradients.pop_front();
				if (gradient !== want) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("gradient mismatch: expected %0d, got %0d", want, gradient);
				end
			end
		end
	end

	function automatic pixel_item_t random_pixel();
		pixel_item_t it;
		logic [127:0] raw;
		raw = {$urandom, $urandom, $urandom, $urandom};
		it = raw[$bits(pixel_item_t)-1:0];
		// Mostly the ratio path, since that is where the arithmetic lives.
		case ($urandom_range(9))
			0: ;
			1: it.outer = 16'd0;
			default: it.inner = 16'd0;
		endcase
		if (it.inner == 16'd0 && it.outer == 16'd0 && $urandom_range(3) != 0)
			it.outer = 16'($urandom_range(65535, 1));
		// Short distances now and then, to reach small and zero distances.
		if ($urandom_range(3) == 0) begin
			it.ix = it.px + 12'($urandom_range(6)) - 12'd3;
			it.iy = it.py + 12'($urandom_range(6)) - 12'd3;
		end
		if ($urandom_range(3) == 0) begin
			it.ox = it.px + 12'($urandom_range(6)) - 12'd3;
			it.oy = it.py + 12'($urandom_range(6)) - 12'd3;
		end
		return it;
	endfunction

	// Corner cases: each special path and the coordinate extremes.
	task automatic test_special_cases();
		pixel_item_t it;
		it = '{12'd5, 12'd5, 16'hFFFF, 16'd0, 12'd0, 12'd0, 12'd0, 12'd0};
		send_pixel(it);                                         // inner masked
		it.inner = 16'd1; it.outer = 16'hFFFF; send_pixel(it);
		it = '{12'd9, 12'd3, 16'd0, 16'd0, 12'd1, 12'd1, 12'd2, 12'd2};
		send_pixel(it);                                         // outer unmasked
		it.outer = 16'd1;
		it.ix = 12'd9; it.iy = 12'd3; it.ox = 12'd9; it.oy = 12'd3;
		send_pixel(it);                                         // both distances zero
		it.ox = 12'd10; send_pixel(it);                         // inner distance zero
		it.ix = 12'd0; it.iy = 12'd0; it.ox = 12'd9; it.oy = 12'd3;
		send_pixel(it);                                         // outer distance zero
		it = '{12'd0, 12'd0, 16'd0, 16'h8000, 12'hFFF, 12'hFFF, 12'hFFF, 12'd0};
		send_pixel(it);
		it = '{12'hFFF, 12'hFFF, 16'd0, 16'hFFFF, 12'd0, 12'd0, 12'd0, 12'hFFF};
		send_pixel(it);
		it = '{12'hFFF, 12'd0, 16'd0, 16'h0001, 12'd0, 12'hFFF, 12'hFFE, 12'd1};
		send_pixel(it);
		it = '{12'hAAA, 12'h555, 16'd0, 16'h5555, 12'h555, 12'hAAA, 12'hAAB, 12'h554};
		send_pixel(it);
		it = '{12'd100, 12'd100, 16'd0, 16'hAAAA, 12'd103, 12'd104, 12'd100, 12'd101};
		send_pixel(it);
	endtask

	task automatic test_random_phase(input int pct, input int count);
		idle_pct = pct;
		repeat (count)
			send_pixel(random_pixel());
		idle_pct = 0;
	endtask

	initial begin
		start = 1'b0;
		pixel_x = '0; pixel_y = '0; inner_sample = '0; outer_sample = '0;
		inner_near_x = '0; inner_near_y = '0; outer_near_x = '0; outer_near_y = '0;
		mismatch_count = 0;
		items_sent = 0;
		results_seen = 0;
		idle_pct = 0;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_special_cases();
		test_random_phase(0, 500);
		test_random_phase(52, 400);
		test_random_phase(13, 300);
		test_random_phase(0, 300);
		start <= 1'b0;

		while (pending_gradients.size() != 0)
			@(posedge clk);
		repeat (PIPE_DEPTH) @(posedge clk);

		$display("Sent %0d pixel items over four idling phases, checked %0d gradients.",
			items_sent, results_seen);
		if (mismatch_count == 0 && pending_gradients.size() == 0)
			$display("mask_gradient_between_boundaries_unit_test: done, clean");
		else
			$display("mask_gradient_between_boundaries_unit_test: done, errors");
		$finish;
	end

	initial begin
		#2ms;
		$display("mask_gradient_between_boundaries_unit_test: done, errors");
		$finish;
	end

endmodule

FILE: files.f
rtl/mgb_pkg.sv
rtl/mgb_front.sv
rtl/mgb_queue.sv
rtl/mgb_back.sv
rtl/mask_gradient_between_boundaries_unit.sv
dv/mask_gradient_between_boundaries_unit_test.sv
